### rtl/core/lcsd_pkg.sv
// Shared types and constants for the LED color shift chain driver.
// No dependencies; imported by every module of the block.
package lcsd_pkg;

  localparam int NIB_W = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] FUNC_SET     = 2'd0;
  localparam logic [1:0] FUNC_CLEAR   = 2'd1;
  localparam logic [1:0] FUNC_REFRESH = 2'd2;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_SHIFT  = 2'd1;
  localparam logic [1:0] KIND_LATCH  = 2'd2;

  localparam logic [2:0] COLOR_NONE  = 3'd0;
  localparam logic [2:0] COLOR_RED   = 3'd1;
  localparam logic [2:0] COLOR_WHITE = 3'd2;
  localparam logic [2:0] COLOR_BLUE  = 3'd3;
  localparam logic [2:0] COLOR_GREEN = 3'd4;

  localparam logic [3:0] CODE_NONE  = 4'h0;
  localparam logic [3:0] CODE_RED   = 4'h1;
  localparam logic [3:0] CODE_GREEN = 4'h2;
  localparam logic [3:0] CODE_BLUE  = 4'h4;
  localparam logic [3:0] CODE_WHITE = 4'h8;

  typedef enum logic [1:0] {
    OP_SET,
    OP_CLEAR,
    OP_BAD,
    OP_REFRESH
  } op_t;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] led_index;
    logic [2:0] color;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       set_ok;
    logic       serial_bit;
    logic       last;
  } out_item_t;

  typedef struct packed {
    op_t              op;
    logic [NIB_W-1:0] nib;
    logic [3:0]       code;
  } cmd_t;

  function automatic logic [3:0] color_code(input logic [2:0] color);
    logic [3:0] code;
    case (color)
      COLOR_RED:   code = CODE_RED;
      COLOR_WHITE: code = CODE_WHITE;
      COLOR_BLUE:  code = CODE_BLUE;
      COLOR_GREEN: code = CODE_GREEN;
      default:     code = CODE_NONE;
    endcase
    return code;
  endfunction

endpackage

### rtl/core/lcsd_front.sv
// Command decoder: classifies an accepted command and maps the LED index
// to its nibble in the frame. Depends on lcsd_pkg.
module lcsd_front #(
  parameter int LED_COUNT   = 12,
  parameter int FRAME_BYTES = 6
) (
  input  lcsd_pkg::in_item_t in_data,
  output lcsd_pkg::cmd_t     cmd
);
  import lcsd_pkg::*;

  localparam int NIBS = 2 * FRAME_BYTES;

  logic [NIB_W-1:0] pos;
  logic             idx_ok;

  always_comb begin
    pos    = NIB_W'(LED_COUNT - 1) - in_data.led_index;
    idx_ok = (in_data.led_index < NIB_W'(LED_COUNT)) && (pos < NIB_W'(NIBS));
    cmd.nib  = pos;
    cmd.code = color_code(in_data.color);
    case (in_data.func)
      FUNC_SET:     cmd.op = idx_ok ? OP_SET : OP_BAD;
      FUNC_CLEAR:   cmd.op = OP_CLEAR;
      FUNC_REFRESH: cmd.op = OP_REFRESH;
      default:      cmd.op = OP_BAD;
    endcase
  end

endmodule

### rtl/core/lcsd_queue.sv
// Short command queue between the decoder and the execution unit.
// Depends on lcsd_pkg for the command type and depth.
module lcsd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lcsd_pkg::cmd_t push_cmd,
  input  logic           pop,
  output lcsd_pkg::cmd_t head_cmd,
  output logic           not_empty,
  output logic           full
);
  import lcsd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign head_cmd  = entries_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### rtl/core/lcsd_back.sv
// Execution unit: holds the LED frame, the sent shadow and the enable
// register, and shifts changed frames out bit by bit. Depends on lcsd_pkg.
module lcsd_back #(
  parameter int FRAME_BYTES = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_data,
  input  logic                cmd_avail,
  input  lcsd_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic                out_valid,
  output lcsd_pkg::out_item_t out_data
);
  import lcsd_pkg::*;

  localparam int NIBS    = 2 * FRAME_BYTES;
  localparam int FRAME_W = 8 * FRAME_BYTES;
  localparam int CNT_W   = $clog2(FRAME_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_LATCH
  } state_t;

  state_t             state_r;
  logic               enable_r;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [FRAME_W-1:0] shadow_r;
  logic [FRAME_W-1:0] shift_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               out_valid_r;
  out_item_t          out_data_r;
  logic               load;

  assign cmd_pop   = (state_r == S_IDLE) && cmd_avail;
  assign load      = cmd_pop && (cmd.op == OP_REFRESH) && enable_r && (frame_r != shadow_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    frame_nxt = frame_r;
    if (cmd_pop) begin
      case (cmd.op)
        OP_SET: begin
          for (int n = 0; n < NIBS; n++) begin
            if (cmd.nib == NIB_W'(n)) begin
              frame_nxt[4*n +: 4] = cmd.code;
            end
          end
        end
        OP_CLEAR: frame_nxt = '0;
        default:  frame_nxt = frame_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      enable_r    <= 1'b0;
      frame_r     <= '0;
      shadow_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      if (cfg_we) begin
        enable_r <= cfg_data;
      end
      frame_r     <= frame_nxt;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      case (state_r)
        S_IDLE: begin
          if (cmd_pop && cmd.op != OP_REFRESH) begin
            out_valid_r       <= 1'b1;
            out_data_r.kind   <= KIND_STATUS;
            out_data_r.set_ok <= (cmd.op != OP_BAD);
            out_data_r.last   <= 1'b1;
          end
          if (load) begin
            shadow_r <= frame_r;
            cnt_r    <= '0;
            state_r  <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          out_valid_r           <= 1'b1;
          out_data_r.kind       <= KIND_SHIFT;
          out_data_r.serial_bit <= shift_r[0];
          cnt_r                 <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(FRAME_W - 1)) begin
            state_r <= S_LATCH;
          end
        end
        S_LATCH: begin
          out_valid_r     <= 1'b1;
          out_data_r.kind <= KIND_LATCH;
          out_data_r.last <= 1'b1;
          state_r         <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shift_r <= frame_r;
    end else if (state_r == S_SHIFT) begin
      shift_r <= shift_r >> 1;
    end
  end

  a_no_pop_while_shifting: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !cmd_pop)
    else $error("command taken while a refresh is in progress");

  a_shadow_matches_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (shadow_r == frame_r))
    else $error("frame changed during a refresh");

  a_latch_after_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.kind == KIND_LATCH) |->
      $past(out_valid_r && out_data_r.kind == KIND_SHIFT))
    else $error("latch pulse without a preceding shift");

  a_load_starts_shift: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (state_r == S_SHIFT) && (cnt_r == '0))
    else $error("refresh load did not start the shift sequence");

endmodule

### rtl/core/led_color_shift_chain_driver_top.sv
// Top level of the LED color shift chain driver: decoder, command queue and
// execution unit. Depends on lcsd_pkg, lcsd_front, lcsd_queue and lcsd_back.
//
// Commands enter when start is high and busy is low; busy rises only when the
// two-entry command queue is full. The execution unit takes one queued command
// per cycle when idle: a set, clear or bad command yields its status result in
// the following cycle. A refresh of a changed frame with the enable bit set
// occupies the execution unit through a load step, a shift step for each frame
// bit and a latch step, so its results arrive on consecutive cycles; a refresh
// that shifts nothing gives no result. Each result is shown for exactly one
// cycle with out_valid high and cannot be held off. The configuration write
// port is always ready.
module led_color_shift_chain_driver_top #(
  parameter int LED_COUNT   = 12,
  parameter int FRAME_BYTES = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lcsd_pkg::in_item_t  in_data,
  output logic                out_valid,
  output lcsd_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import lcsd_pkg::*;

  cmd_t dec_cmd;
  cmd_t head_cmd;
  logic q_not_empty;
  logic q_full;
  logic q_pop;
  logic accept;

  assign busy      = q_full;
  assign accept    = start && !q_full;
  assign cfg_ready = 1'b1;

  lcsd_front #(
    .LED_COUNT  (LED_COUNT),
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .in_data(in_data),
    .cmd    (dec_cmd)
  );

  lcsd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_cmd (dec_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .not_empty(q_not_empty),
    .full     (q_full)
  );

  lcsd_back #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd_avail(q_not_empty),
    .cmd      (head_cmd),
    .cmd_pop  (q_pop),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

### bench/testbench.sv
// Self-checking testbench for led_color_shift_chain_driver_top: directed and random
// commands against an in-bench model of the LED frame and the shift chain.
// Depends on lcsd_pkg and the RTL of the block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lcsd_pkg::*;

  localparam int LEDS = 12;
  localparam int BYTES = 6;
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT = 4000;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [2:0] COLOR_SPARE = 3'd5;
  localparam logic [2:0] COLOR_TOP   = 3'd7;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_item_t   in_data = '0;
  logic       out_valid;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;

  logic [7:0] frame_img [BYTES];
  logic [7:0] shown_img [BYTES];
  logic       chain_enable;
  out_item_t  chain_results [$];
  int         failures;
  int         stall_cycles;
  bit         steady;

  led_color_shift_chain_driver_top #(
    .LED_COUNT(LEDS),
    .FRAME_BYTES(BYTES)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [3:0] led_code(input logic [2:0] color);
    case (color)
      COLOR_RED:   return CODE_RED;
      COLOR_WHITE: return CODE_WHITE;
      COLOR_BLUE:  return CODE_BLUE;
      COLOR_GREEN: return CODE_GREEN;
      default:     return CODE_NONE;
    endcase
  endfunction

  function automatic bit store_led(input int idx, input logic [3:0] code);
    int pos;
    int byte_sel;
    if (idx >= LEDS) return 1'b0;
    pos = LEDS - 1 - idx;
    byte_sel = pos / 2;
    if (byte_sel >= BYTES) return 1'b0;
    if (pos % 2 == 0) frame_img[byte_sel][3:0] = code;
    else frame_img[byte_sel][7:4] = code;
    return 1'b1;
  endfunction

  function automatic void push_result(input logic [1:0] kind, input logic ok,
                                      input logic bit_val, input logic is_last);
    chain_results.push_back(out_item_t'{kind: kind, set_ok: ok,
                                        serial_bit: bit_val, last: is_last});
  endfunction

  function automatic void model_request(input in_item_t item);
    bit ok;
    bit changed;
    changed = 1'b0;
    case (item.func)
      FUNC_SET: begin
        ok = store_led(int'(item.led_index), led_code(item.color));
        push_result(KIND_STATUS, ok, 1'b0, 1'b1);
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < LEDS; i++) ok = store_led(i, CODE_NONE);
        push_result(KIND_STATUS, 1'b1, 1'b0, 1'b1);
      end
      FUNC_REFRESH: begin
        if (chain_enable) begin
          for (int i = 0; i < BYTES; i++) begin
            if (shown_img[i] != frame_img[i]) begin
              shown_img[i] = frame_img[i];
              changed = 1'b1;
            end
          end
          if (changed) begin
            for (int i = 0; i < BYTES; i++)
              for (int j = 0; j < 8; j++)
                push_result(KIND_SHIFT, 1'b0, shown_img[i][j], 1'b0);
            push_result(KIND_LATCH, 1'b0, 1'b0, 1'b1);
          end
        end
      end
      default: push_result(KIND_STATUS, 1'b0, 1'b0, 1'b1);
    endcase
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (chain_results.size() == 0) begin
        $error("result with nothing expected: %p", out_data);
        failures++;
      end else begin
        want = chain_results.pop_front();
        if (out_data.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_data.kind);
          failures++;
        end
        if (out_data.set_ok !== want.set_ok) begin
          $error("set_ok: expected %0b, got %0b", want.set_ok, out_data.set_ok);
          failures++;
        end
        if (out_data.serial_bit !== want.serial_bit) begin
          $error("serial_bit: expected %0b, got %0b", want.serial_bit,
                 out_data.serial_bit);
          failures++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_data.last);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_request(input in_item_t item);
    if (!steady) begin
      while ($urandom_range(0, 99) < 24) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    in_data <= item;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    model_request(item);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (chain_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input logic value);
    drain();
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    chain_enable = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_disabled_commands;
    write_enable(1'b0);
    send_request(in_item_t'{FUNC_SET, 4'd0, COLOR_RED});
    send_request(in_item_t'{FUNC_SET, 4'd11, COLOR_WHITE});
    send_request(in_item_t'{FUNC_SET, 4'd12, COLOR_BLUE});
    send_request(in_item_t'{FUNC_SET, 4'd15, COLOR_GREEN});
    send_request(in_item_t'{FUNC_SET, 4'd5, COLOR_TOP});
    send_request(in_item_t'{FUNC_SET, 4'd6, COLOR_GREEN});
    send_request(in_item_t'{FUNC_SET, 4'd1, COLOR_SPARE});
    send_request(in_item_t'{FUNC_SET, 4'd7, COLOR_BLUE});
    send_request(in_item_t'{FUNC_UNUSED, 4'd15, COLOR_TOP});
    send_request(in_item_t'{FUNC_REFRESH, 4'd0, COLOR_NONE});
  endtask

  task automatic test_enabled_refresh;
    write_enable(1'b1);
    send_request(in_item_t'{FUNC_REFRESH, 4'd15, COLOR_TOP});
    send_request(in_item_t'{FUNC_REFRESH, 4'd0, COLOR_NONE});
    send_request(in_item_t'{FUNC_SET, 4'd3, COLOR_BLUE});
    send_request(in_item_t'{FUNC_SET, 4'd10, COLOR_NONE});
    send_request(in_item_t'{FUNC_REFRESH, 4'd0, COLOR_NONE});
    send_request(in_item_t'{FUNC_CLEAR, 4'd9, COLOR_RED});
    send_request(in_item_t'{FUNC_REFRESH, 4'd0, COLOR_NONE});
    send_request(in_item_t'{FUNC_CLEAR, 4'd0, COLOR_NONE});
    send_request(in_item_t'{FUNC_REFRESH, 4'd0, COLOR_NONE});
    send_request(in_item_t'{FUNC_UNUSED, 4'd0, COLOR_NONE});
  endtask

  task automatic test_random_traffic(input int count, input logic enable,
                                     input int steady_count);
    in_item_t item;
    int pick;
    write_enable(enable);
    for (int n = 0; n < count; n++) begin
      steady = (n < steady_count);
      pick = $urandom_range(0, 99);
      item.led_index = 4'($urandom_range(0, 15));
      item.color = 3'($urandom_range(0, 7));
      if (pick < 60) item.func = FUNC_SET;
      else if (pick < 82) item.func = FUNC_REFRESH;
      else if (pick < 90) item.func = FUNC_CLEAR;
      else item.func = FUNC_UNUSED;
      send_request(item);
    end
    steady = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < BYTES; i++) begin
      frame_img[i] = '0;
      shown_img[i] = '0;
    end
    chain_enable = 1'b0;
    failures = 0;
    steady = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_disabled_commands();
    test_enabled_refresh();
    test_random_traffic(30, 1'b1, 0);
    test_random_traffic(20, 1'b0, 0);
    test_random_traffic(30, 1'b1, 20);

    drain();
    if (failures == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
